[hw/rtl/point_to_pixel_lookup_macros.svh]
// assertion macros for the point to pixel lookup block
`ifndef POINT_TO_PIXEL_LOOKUP_MACROS_SVH
`define POINT_TO_PIXEL_LOOKUP_MACROS_SVH

// same-cycle implication, checked out of reset
`define PTPL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define PTPL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/ptpl_pkg.sv]
// shared constants and types for the point to pixel lookup block
package ptpl_pkg;

  localparam int PTPL_MAX_PIXELS = 256;
  localparam int PTPL_COORD_BITS = 16;
  localparam int PIX_IDX_W       = 8;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_QUERY = 1'b1
  } req_type_t;

endpackage

[hw/rtl/point_to_pixel_lookup.sv]
// point to pixel lookup: rectangle table with a sequential point search
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid / in_stall   | req_type, pos_x, pos_y, rect_width, rect_height
//   out     | output    | out_valid / out_stall | hit, pixel_index, table_full
//
// a load does the table write (none when the table is full), then the result move to the output register
// a query reads the table entries in order, up to the entry count: one table read per
//   cycle from the read port of the rectangle memory, compared in the next cycle
// reset clears the entry count and handshake state; the table is not cleared
// in_stall is high while an item is in work; a stalled result waits in the output
//   register while the next item is accepted and worked on
`include "point_to_pixel_lookup_macros.svh"

module point_to_pixel_lookup #(
  parameter int MAX_PIXELS = ptpl_pkg::PTPL_MAX_PIXELS,
  parameter int COORD_BITS = ptpl_pkg::PTPL_COORD_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_req_type,
  input  logic [COORD_BITS-1:0]           in_pos_x,
  input  logic [COORD_BITS-1:0]           in_pos_y,
  input  logic [COORD_BITS-1:0]           in_rect_width,
  input  logic [COORD_BITS-1:0]           in_rect_height,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_hit,
  output logic [ptpl_pkg::PIX_IDX_W-1:0]  out_pixel_index,
  output logic                            out_table_full
);
  import ptpl_pkg::*;

  localparam int IDX_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int CNT_W = $clog2(MAX_PIXELS + 1);

  // right and top edges are kept one bit wider so they never wrap
  typedef struct packed {
    logic [COORD_BITS:0]   top;
    logic [COORD_BITS:0]   right;
    logic [COORD_BITS-1:0] bottom;
    logic [COORD_BITS-1:0] left;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t                 state_r;
  logic [CNT_W-1:0]       count_r;
  logic [CNT_W-1:0]       issue_idx_r;
  logic                   pend_r;
  logic [IDX_W-1:0]       pend_idx_r;
  logic [COORD_BITS-1:0]  qx_r;
  logic [COORD_BITS-1:0]  qy_r;
  logic                   res_hit_r;
  logic [PIX_IDX_W-1:0]   res_idx_r;
  logic                   res_full_r;
  logic                   out_valid_r;
  logic                   out_hit_r;
  logic [PIX_IDX_W-1:0]   out_pixel_index_r;
  logic                   out_table_full_r;

  entry_t                 mem [MAX_PIXELS];
  entry_t                 rd_data_r;
  entry_t                 wr_entry;
  logic                   wr_en;
  logic                   rd_en;
  logic [IDX_W-1:0]       rd_addr;

  logic                   in_accept;
  logic                   is_load;
  logic                   table_is_full;
  logic                   more_to_read;
  logic                   match;
  logic                   out_free;
  logic [IDX_W+PIX_IDX_W-1:0] pend_idx_ext;
  logic [CNT_W+PIX_IDX_W-1:0] count_ext;

  assign in_stall      = (state_r != S_IDLE);
  assign in_accept     = in_valid && !in_stall;
  assign is_load       = (in_req_type == REQ_LOAD);
  assign table_is_full = (count_r == CNT_W'(MAX_PIXELS));
  assign more_to_read  = (issue_idx_r < count_r);
  assign out_free      = !out_valid_r || !out_stall;

  // loads and scans never overlap, and a scan reads only below the count,
  // so the write and read ports never meet on one entry
  assign wr_en   = in_accept && is_load && !table_is_full;
  assign rd_en   = (state_r == S_SCAN) && more_to_read;
  assign rd_addr = issue_idx_r[IDX_W-1:0];

  assign wr_entry.left   = in_pos_x;
  assign wr_entry.bottom = in_pos_y;
  assign wr_entry.right  = {1'b0, in_pos_x} + {1'b0, in_rect_width};
  assign wr_entry.top    = {1'b0, in_pos_y} + {1'b0, in_rect_height};

  // inclusive bounds on all four sides
  assign match = pend_r
      && (rd_data_r.left <= qx_r) && ({1'b0, qx_r} <= rd_data_r.right)
      && (rd_data_r.bottom <= qy_r) && ({1'b0, qy_r} <= rd_data_r.top);

  assign pend_idx_ext = {{PIX_IDX_W{1'b0}}, pend_idx_r};
  assign count_ext    = {{PIX_IDX_W{1'b0}}, count_r};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[IDX_W-1:0]] <= wr_entry;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // in the done state a leaving word is replaced by the new one there
      if (out_valid_r && !out_stall && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            if (is_load) begin
              res_full_r <= table_is_full;
              res_hit_r  <= !table_is_full;
              res_idx_r  <= table_is_full ? '0 : count_ext[PIX_IDX_W-1:0];
              if (!table_is_full) begin
                count_r <= count_r + CNT_W'(1);
              end
              state_r <= S_DONE;
            end else begin
              qx_r        <= in_pos_x;
              qy_r        <= in_pos_y;
              issue_idx_r <= '0;
              pend_r      <= 1'b0;
              res_full_r  <= 1'b0;
              state_r     <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (match) begin
            res_hit_r <= 1'b1;
            res_idx_r <= pend_idx_ext[PIX_IDX_W-1:0];
            pend_r    <= 1'b0;
            state_r   <= S_DONE;
          end else if (!more_to_read) begin
            res_hit_r <= 1'b0;
            res_idx_r <= '0;
            pend_r    <= 1'b0;
            state_r   <= S_DONE;
          end else begin
            pend_r      <= 1'b1;
            pend_idx_r  <= issue_idx_r[IDX_W-1:0];
            issue_idx_r <= issue_idx_r + CNT_W'(1);
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r       <= 1'b1;
            out_hit_r         <= res_hit_r;
            out_pixel_index_r <= res_idx_r;
            out_table_full_r  <= res_full_r;
            state_r           <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_pixel_index = out_pixel_index_r;
  assign out_table_full  = out_table_full_r;

  `PTPL_ASSERT_NOW(a_count_bounded, 1'b1, count_r <= CNT_W'(MAX_PIXELS), "count past size")
  `PTPL_ASSERT_NOW(a_read_below_count, rd_en, issue_idx_r < count_r, "read past count")
  `PTPL_ASSERT_NOW(a_full_never_hit, out_valid_r, !(out_hit_r && out_table_full_r), "hit and full")
  `PTPL_ASSERT_NEXT(a_count_only_on_load, !(in_accept && is_load), $stable(count_r), "count moved")

endmodule
